FILE: rtl/sida_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
package sida_pkg;

  localparam int DATA_W      = 32;
  // Decimal digits enough for any magnitude of DATA_W bits (78/256 > log10 2).
  localparam int DATA_DIGITS = (DATA_W * 78) / 256 + 1;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Commands from the sequencer to the converter.
  typedef struct packed {
    logic load;         // start a new conversion
    logic digit_shift;  // drop the top BCD digit, shift the rest up
  } sida_ctl_t;

  // Status from the converter to the sequencer.
  typedef struct packed {
    logic       done;       // all magnitude bits shifted in
    logic [3:0] top_digit;  // most significant remaining BCD digit
  } sida_sts_t;

endpackage

FILE: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII text, one character per transfer.
//
// Input channel (in_valid/in_ready/in_value): one two's complement integer per
// transfer. Output channel (out_valid/out_ready/out_character/out_last): the
// decimal text, most significant character first, '-' ahead of a negative
// value, no leading zeros, out_last high on the final character. No terminator.
//
// One item at a time. After the input transfer the magnitude is shifted into
// a shift-and-add-3 BCD converter one bit per cycle until the converter is
// done. Then the sequencer walks all NDIG BCD digits from the top, one digit
// per cycle unless a stalled receiver holds the output register: leading zeros
// are dropped without output, every other digit (and the sign first) goes to
// the output register.
// in_ready is high once the last character sits in the output register, so
// the next value transfers while that character still waits for out_ready.
//
// A stalled receiver simply holds the output register; the sequencer waits.
// Reset (rst_n, synchronous, low) empties the output register and returns the
// sequencer to idle; a conversion in flight is dropped.
module signed_int_to_decimal_ascii
  import sida_pkg::*;
#(
  parameter int WIDTH = DATA_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [WIDTH-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_character,
  output logic                    out_last
);

  localparam int NDIG = (WIDTH * 78) / 256 + 1;
  localparam int LW   = $clog2(NDIG + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic          sign_pend_r, sign_pend_nxt;  // '-' still to be sent
  logic          started_r, started_nxt;      // first nonzero digit seen
  logic [LW-1:0] left_r, left_nxt;            // BCD digits not yet consumed
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;

  logic             in_xfer;
  logic             out_free;
  logic [WIDTH-1:0] mag;
  sida_ctl_t        ctl;
  sida_sts_t        sts;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Unsigned negate: the most negative value maps to 2^(WIDTH-1) exactly.
  assign mag = in_value[WIDTH-1] ? (WIDTH'(0) - WIDTH'(in_value)) : WIDTH'(in_value);

  sida_dabble #(
    .WIDTH (WIDTH),
    .NDIG  (NDIG)
  ) u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .mag   (mag),
    .sts   (sts)
  );

  always_comb begin
    state_nxt       = state_r;
    sign_pend_nxt   = sign_pend_r;
    started_nxt     = started_r;
    left_nxt        = left_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_char_nxt    = out_char_r;
    out_last_nxt    = out_last_r;
    ctl.load        = 1'b0;
    ctl.digit_shift = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          ctl.load      = 1'b1;
          sign_pend_nxt = in_value[WIDTH-1];
          started_nxt   = 1'b0;
          left_nxt      = LW'(NDIG);
          state_nxt     = ST_CONV;
        end
      end
      ST_CONV: begin
        if (sts.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sign_pend_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = CHAR_MINUS;
            out_last_nxt  = 1'b0;
            sign_pend_nxt = 1'b0;
          end
        end else if (!started_r && sts.top_digit == 4'd0 && left_r != LW'(1)) begin
          // leading zero: consume silently
          ctl.digit_shift = 1'b1;
          left_nxt        = left_r - LW'(1);
        end else if (out_free) begin
          ctl.digit_shift = 1'b1;
          out_valid_nxt   = 1'b1;
          out_char_nxt    = CHAR_ZERO | {4'b0000, sts.top_digit};
          out_last_nxt    = (left_r == LW'(1));
          started_nxt     = 1'b1;
          left_nxt        = left_r - LW'(1);
          if (left_r == LW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
      started_r   <= 1'b0;
      left_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
      started_r   <= started_nxt;
      left_r      <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

FILE: rtl/sida_dabble.sv
// Bit-serial binary to BCD converter (shift and add-3) with a digit shift-out.
module sida_dabble
  import sida_pkg::*;
#(
  parameter int WIDTH = DATA_W,
  parameter int NDIG  = DATA_DIGITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sida_ctl_t        ctl,
  input  logic [WIDTH-1:0] mag,
  output sida_sts_t        sts
);

  localparam int CW = $clog2(WIDTH + 1);
  localparam int BW = 4 * NDIG;

  logic [WIDTH-1:0] bin_r, bin_nxt;
  logic [BW-1:0]    bcd_r, bcd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [BW-1:0]    adj;

  // Add 3 to every digit of 5 or more ahead of the next doubling.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      bin_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = CW'(WIDTH);
    end else if (cnt_r != '0) begin
      bin_nxt = {bin_r[WIDTH-2:0], 1'b0};
      bcd_nxt = {adj[BW-2:0], bin_r[WIDTH-1]};
      cnt_nxt = cnt_r - CW'(1);
    end else if (ctl.digit_shift) begin
      bcd_nxt = {bcd_r[BW-5:0], 4'b0000};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign sts.done      = (cnt_r == '0);
  assign sts.top_digit = bcd_r[BW-1 -: 4];

endmodule

FILE: rtl/sida_checker.sv
// Port-level checker for the converter, bound to the top level.
module sida_checker
  import sida_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_character,
  input logic       out_last
);

  // A stalled character holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("stalled output changed");

  // Only '-' or a digit ever leaves the block.
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS) ||
                  (out_character >= CHAR_ZERO && out_character <= (CHAR_ZERO + 8'd9)))
    else $error("character outside the decimal set");

  // The sign is never the last character.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == CHAR_MINUS |-> !out_last)
    else $error("minus sign flagged last");

  // Ready for a new value only once the last character of the previous run sits in the output register.
  a_ready_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && out_valid |-> out_last)
    else $error("input ready with a run still in progress");

  // Busy right after a transfer.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready directly after a transfer");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (.*);
